@@ design/csr_sparse_matvec_macros.svh @@
// Assertion helpers for the sparse matrix-vector block.
// Both macros check on the rising clock edge and are disabled while reset is low.
`ifndef CSR_SPARSE_MATVEC_MACROS_SVH
`define CSR_SPARSE_MATVEC_MACROS_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("csm assertion failed");
`define CSM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("csm assertion failed");
`else
`define CSM_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define CSM_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ design/csm_pkg.sv @@
package csm_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 64;
    localparam int ROW_W   = 10;

    // Operation queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_NZ    = 2'd1,
        CMD_EMPTY = 2'd2
    } t_cmd;

    // One accumulate step for the back part. An empty row is a zero product
    // that closes the row.
    typedef struct packed {
        logic               emit;
        logic [SUM_W-1:0]   product;
    } t_op;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [ROW_W-1:0]   row;
        logic               sat;
    } t_res;

endpackage

@@ design/csm_front.sv @@
`include "csr_sparse_matvec_macros.svh"

module csm_front #(
    parameter int VEC_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_cmd,
    input  logic [csm_pkg::IDX_W-1:0]          i_index,
    input  logic signed [csm_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_row_end,
    input  logic [csm_pkg::Q_CNT_W-1:0]        i_q_count,
    output logic                               o_op_valid,
    output csm_pkg::t_op                       o_op
);

    localparam int ADDR_W = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

    logic                                 w_accept;
    logic                                 w_load;
    logic                                 w_op_v;
    logic                                 w_is_nz;
    logic                                 w_emit;
    logic                                 w_in_range;
    logic [ADDR_W+csm_pkg::IDX_W-1:0]     w_addr_ext;
    logic [ADDR_W-1:0]                    w_addr;
    logic signed [csm_pkg::SUM_W-1:0]     w_prod;

    logic [csm_pkg::VAL_W-1:0]            r_mem [VEC_DEPTH];
    logic signed [csm_pkg::VAL_W-1:0]     r_rd_data;

    logic                                 r_s1_v;
    logic                                 r_s1_nz;
    logic                                 r_s1_emit;
    logic                                 r_s1_inr;
    logic signed [csm_pkg::VAL_W-1:0]     r_s1_val;

    logic                                 r_s2_v;
    logic                                 r_s2_emit;
    logic [csm_pkg::SUM_W-1:0]            r_s2_prod;

    // Credits: every operation in the two stages or in the queue holds a slot.
    assign full = (csm_pkg::Q_CNT_W'(r_s1_v) + csm_pkg::Q_CNT_W'(r_s2_v) + i_q_count)
                  >= csm_pkg::Q_CNT_W'(csm_pkg::Q_DEPTH);
    assign w_accept = push && !full;

    assign w_in_range = (32'(i_index) < 32'(VEC_DEPTH));
    assign w_addr_ext = {{ADDR_W{1'b0}}, i_index};
    assign w_addr     = w_addr_ext[ADDR_W-1:0];

    always_comb begin
        w_load  = 1'b0;
        w_op_v  = 1'b0;
        w_is_nz = 1'b0;
        w_emit  = 1'b0;
        unique case (csm_pkg::t_cmd'(i_cmd))
            csm_pkg::CMD_LOAD: begin
                w_load = w_accept;
            end
            csm_pkg::CMD_NZ: begin
                w_op_v  = w_accept;
                w_is_nz = 1'b1;
                w_emit  = i_row_end;
            end
            csm_pkg::CMD_EMPTY: begin
                w_op_v = w_accept;
                w_emit = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_in_range) begin
            r_mem[w_addr] <= i_value;
        end
        r_rd_data <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_nz   <= w_is_nz;
        r_s1_emit <= w_emit;
        r_s1_inr  <= w_in_range;
        r_s1_val  <= i_value;
        r_s2_emit <= r_s1_emit;
        r_s2_prod <= (r_s1_nz && r_s1_inr) ? w_prod : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_op_v;
            r_s2_v <= r_s1_v;
        end
    end

    // Both operands are signed, so they are sign-extended to the product width.
    assign w_prod = csm_pkg::SUM_W'(r_s1_val) * csm_pkg::SUM_W'(r_rd_data);

    assign o_op_valid   = r_s2_v;
    assign o_op.emit    = r_s2_emit;
    assign o_op.product = r_s2_prod;

    `CSM_ASSERT_NEXT(a_front_pipe, i_clk, i_rst_n, w_op_v, r_s1_v)

endmodule

@@ design/csm_queue.sv @@
`include "csr_sparse_matvec_macros.svh"

module csm_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  csm_pkg::t_op                  i_op,
    input  logic                          i_pop,
    output logic                          o_empty,
    output csm_pkg::t_op                  o_head,
    output logic [csm_pkg::Q_CNT_W-1:0]   o_count
);

    csm_pkg::t_op                  r_mem [csm_pkg::Q_DEPTH];
    logic [csm_pkg::Q_PTR_W-1:0]   r_wr;
    logic [csm_pkg::Q_PTR_W-1:0]   r_rd;
    logic [csm_pkg::Q_CNT_W-1:0]   r_count;
    logic                          w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + csm_pkg::Q_CNT_W'(i_push) - csm_pkg::Q_CNT_W'(w_pop);
        end
    end

    // The front part reserves a slot before it accepts, so a push never finds the queue full.
    `CSM_ASSERT_IMPLY(a_queue_no_overflow, i_clk, i_rst_n, i_push,
                      r_count != csm_pkg::Q_CNT_W'(csm_pkg::Q_DEPTH))

endmodule

@@ design/csm_back.sv @@
`include "csr_sparse_matvec_macros.svh"

module csm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_valid,
    input  csm_pkg::t_op                       i_head,
    output logic                               o_take,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [csm_pkg::SUM_W-1:0]   o_row_sum,
    output logic [csm_pkg::ROW_W-1:0]          o_row_number,
    output logic                               o_saturated
);

    localparam logic [csm_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(csm_pkg::SUM_W-1){1'b1}}};
    localparam logic [csm_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(csm_pkg::SUM_W-1){1'b0}}};

    logic [csm_pkg::SUM_W-1:0]   r_acc;
    logic                        r_clip;
    logic [csm_pkg::ROW_W-1:0]   r_row;

    csm_pkg::t_res               r_res [2];
    logic                        r_owr;
    logic                        r_ord;
    logic [1:0]                  r_ocnt;

    logic [csm_pkg::SUM_W:0]     w_sum;
    logic                        w_ovf;
    logic [csm_pkg::SUM_W-1:0]   w_acc_n;
    logic                        w_clip_n;
    logic                        w_wr;
    logic                        w_rd;
    csm_pkg::t_res               w_res;

    // A step is taken only when the result buffer has room for a possible row result.
    assign o_take = i_head_valid && (r_ocnt != 2'd2);
    assign w_wr   = o_take && i_head.emit;
    assign w_rd   = pop && (r_ocnt != 2'd0);

    // Saturating add: overflow shows as a carry into the extra sign bit that
    // disagrees with the sign of the 64-bit sum.
    assign w_sum    = {r_acc[csm_pkg::SUM_W-1], r_acc}
                    + {i_head.product[csm_pkg::SUM_W-1], i_head.product};
    assign w_ovf    = w_sum[csm_pkg::SUM_W] != w_sum[csm_pkg::SUM_W-1];
    assign w_acc_n  = w_ovf ? (w_sum[csm_pkg::SUM_W] ? SUM_MIN : SUM_MAX)
                            : w_sum[csm_pkg::SUM_W-1:0];
    assign w_clip_n = r_clip || w_ovf;

    assign w_res.sum = w_acc_n;
    assign w_res.row = r_row;
    assign w_res.sat = w_clip_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
            r_row  <= '0;
        end else if (o_take) begin
            if (i_head.emit) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
                r_row  <= r_row + 1'b1;
            end else begin
                r_acc  <= w_acc_n;
                r_clip <= w_clip_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_res[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_owr <= ~r_owr;
            end
            if (w_rd) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    assign empty        = (r_ocnt == 2'd0);
    assign o_row_sum    = r_res[r_ord].sum;
    assign o_row_number = r_res[r_ord].row;
    assign o_saturated  = r_res[r_ord].sat;

    `CSM_ASSERT_NEXT(a_row_close_clears, i_clk, i_rst_n, o_take && i_head.emit,
                     (r_acc == '0) && !r_clip)
    `CSM_ASSERT_IMPLY(a_result_no_overflow, i_clk, i_rst_n, w_wr, r_ocnt != 2'd2)

endmodule

@@ design/csr_sparse_matvec.sv @@
// Streaming sparse matrix times dense vector in compressed-row order. Load the
// dense vector first with load transactions (cmd 0), then stream the nonzeros
// (cmd 1) row by row, marking the last nonzero of each row with row_end; an
// empty row is a single cmd 2 transaction. Every closed row produces one result
// transaction with the saturated Q32.32 row sum, the row number (wrapping at
// 1024) and a flag telling whether the accumulator clipped in that row. The
// block takes one input transaction per cycle with no bubbles while full is
// low, including a nonzero right after the load of the element it reads; a row
// result becomes visible once the transaction that closes its row has passed
// through the two front stages, the queue and the result buffer. The sustained
// rate is set by the single port of the vector memory and the saturating
// accumulate. The vector memory is not cleared by reset: reading an element
// that was never loaded returns an arbitrary value, and there is no clearing
// pass after reset. Loads at indices at or above VEC_DEPTH are dropped, and
// nonzeros at such columns contribute zero.
//
// Structure: the front part decodes each transaction, owns the vector memory
// and forms the 64-bit product in two registered stages. Its output is a
// stream of accumulate steps that enters a short queue. The back part drains
// the queue into the saturating accumulator and writes row results into a
// two-entry result buffer that drives the output side. The front part
// reserves a queue slot per operation before it accepts a transaction, so a
// stall at the result side backs up into full without losing anything.

module csr_sparse_matvec #(
    parameter int VEC_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_cmd,
    input  logic [csm_pkg::IDX_W-1:0]          i_index,
    input  logic signed [csm_pkg::VAL_W-1:0]   i_value,
    input  logic                               i_row_end,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [csm_pkg::SUM_W-1:0]   o_row_sum,
    output logic [csm_pkg::ROW_W-1:0]          o_row_number,
    output logic                               o_saturated
);

    logic                          w_op_valid;
    csm_pkg::t_op                  w_op;
    logic [csm_pkg::Q_CNT_W-1:0]   w_q_count;
    logic                          w_q_empty;
    csm_pkg::t_op                  w_q_head;
    logic                          w_take;

    // Decode, vector memory and multiply.
    csm_front #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_index    (i_index),
        .i_value    (i_value),
        .i_row_end  (i_row_end),
        .i_q_count  (w_q_count),
        .o_op_valid (w_op_valid),
        .o_op       (w_op)
    );

    // Accumulate steps waiting for the back part.
    csm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_valid),
        .i_op    (w_op),
        .i_pop   (w_take),
        .o_empty (w_q_empty),
        .o_head  (w_q_head),
        .o_count (w_q_count)
    );

    // Saturating accumulation and the result buffer.
    csm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!w_q_empty),
        .i_head       (w_q_head),
        .o_take       (w_take),
        .pop          (pop),
        .empty        (empty),
        .o_row_sum    (o_row_sum),
        .o_row_number (o_row_number),
        .o_saturated  (o_saturated)
    );

endmodule
